FILE: rtl/core/klex_pkg.sv
// shared constants, types and keyword tables of the lexer
package klex_pkg;

    localparam int MAX_LEXEME_DEF = 16;
    localparam int NUM_KW         = 13;

    // scan modes
    localparam logic [4:0] M_IDLE  = 5'd0;
    localparam logic [4:0] M_IDENT = 5'd1;
    localparam logic [4:0] M_INT   = 5'd2;
    localparam logic [4:0] M_FRAC  = 5'd3;
    localparam logic [4:0] M_DOT   = 5'd4;
    localparam logic [4:0] M_S     = 5'd5;
    localparam logic [4:0] M_ST    = 5'd6;
    localparam logic [4:0] M_STA   = 5'd7;
    localparam logic [4:0] M_STAR  = 5'd8;
    localparam logic [4:0] M_START = 5'd9;
    localparam logic [4:0] M_E     = 5'd10;
    localparam logic [4:0] M_EN    = 5'd11;
    localparam logic [4:0] M_END   = 5'd12;
    localparam logic [4:0] M_OP    = 5'd13;

    // pending operator
    localparam logic [2:0] P_NONE = 3'd0;
    localparam logic [2:0] P_BAR  = 3'd1;
    localparam logic [2:0] P_BANG = 3'd2;
    localparam logic [2:0] P_GT   = 3'd3;
    localparam logic [2:0] P_LT   = 3'd4;
    localparam logic [2:0] P_EQ   = 3'd5;

    // token kinds
    localparam logic [5:0] K_ERR   = 6'd0;
    localparam logic [5:0] K_IDENT = 6'd1;
    localparam logic [5:0] K_NUM   = 6'd2;
    localparam logic [5:0] K_KW0   = 6'd3;
    localparam logic [5:0] K_START = 6'd16;
    localparam logic [5:0] K_END   = 6'd17;
    localparam logic [5:0] K_OP0   = 6'd18;
    localparam logic [5:0] K_OROR  = 6'd31;
    localparam logic [5:0] K_NE    = 6'd32;
    localparam logic [5:0] K_GT    = 6'd33;
    localparam logic [5:0] K_GE    = 6'd34;
    localparam logic [5:0] K_LT    = 6'd35;
    localparam logic [5:0] K_LE    = 6'd36;
    localparam logic [5:0] K_EQ    = 6'd37;
    localparam logic [5:0] K_EQEQ  = 6'd38;

    // output beat source
    localparam logic [2:0] OSEL_NONE   = 3'd0;
    localparam logic [2:0] OSEL_DIRECT = 3'd1;
    localparam logic [2:0] OSEL_PRE    = 3'd2;
    localparam logic [2:0] OSEL_WORD   = 3'd3;
    localparam logic [2:0] OSEL_TAIL   = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       step_direct;
        logic       tail;
        logic       word_start;
        logic       word_next;
        logic [2:0] osel;
    } klex_cmd_t;

    typedef struct packed {
        logic is_direct;
        logic dir_emit;
        logic pre_word;
        logic pre_beat;
        logic tail_emit;
        logic word_last;
        logic out_free;
    } klex_stat_t;

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        case (k)
            4'd0:    return 4'd5;
            4'd1:    return 4'd4;
            4'd2:    return 4'd6;
            4'd3:    return 4'd4;
            4'd4:    return 4'd8;
            4'd5:    return 4'd6;
            4'd6:    return 4'd5;
            4'd7:    return 4'd2;
            4'd8:    return 4'd3;
            4'd9:    return 4'd5;
            4'd10:   return 4'd5;
            4'd11:   return 4'd3;
            4'd12:   return 4'd8;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [63:0] kw_word(input logic [3:0] k);
        case (k)
            4'd0:    return 64'("point");
            4'd1:    return 64'("wall");
            4'd2:    return 64'("window");
            4'd3:    return 64'("door");
            4'd4:    return 64'("distance");
            4'd5:    return 64'("return");
            4'd6:    return 64'("ratio");
            4'd7:    return 64'("if");
            4'd8:    return 64'("int");
            4'd9:    return 64'("float");
            4'd10:   return 64'("floor");
            4'd11:   return 64'("for");
            4'd12:   return 64'("building");
            default: return 64'd0;
        endcase
    endfunction

    // character at position p (first character is the most significant byte)
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
        logic [63:0] w;
        logic [3:0]  sh;
        w  = kw_word(k);
        sh = kw_len(k) - 4'd1 - {1'b0, p};
        w  = w >> {sh, 3'b000};
        return w[7:0];
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || c == 8'd10 || c == 8'd9;
    endfunction

    // bit 6 set when c is a single-character operator, low bits the kind
    function automatic logic [6:0] single_op(input logic [7:0] c);
        case (c)
            "+":     return {1'b1, K_OP0 + 6'd0};
            "-":     return {1'b1, K_OP0 + 6'd1};
            "/":     return {1'b1, K_OP0 + 6'd2};
            "*":     return {1'b1, K_OP0 + 6'd3};
            "(":     return {1'b1, K_OP0 + 6'd4};
            ")":     return {1'b1, K_OP0 + 6'd5};
            "{":     return {1'b1, K_OP0 + 6'd6};
            "}":     return {1'b1, K_OP0 + 6'd7};
            "[":     return {1'b1, K_OP0 + 6'd8};
            "]":     return {1'b1, K_OP0 + 6'd9};
            ";":     return {1'b1, K_OP0 + 6'd10};
            ",":     return {1'b1, K_OP0 + 6'd11};
            "&":     return {1'b1, K_OP0 + 6'd12};
            default: return {1'b0, K_ERR};
        endcase
    endfunction

endpackage

FILE: rtl/core/klex_ram.sv
// generic single-port-write ram with registered read
module klex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/klex_datapath.sv
// lexer datapath: scan state, lexeme buffer, keyword matching and output register
module klex_datapath
    import klex_pkg::*;
#(
    parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] in_char,
    input  logic       in_eoi,
    input  klex_cmd_t  cmd,
    output klex_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] out_kind,
    output logic [7:0] out_char,
    output logic       out_last,
    output logic       out_trunc
);

    localparam int AW = (MAX_LEXEME > 1) ? $clog2(MAX_LEXEME) : 1;
    localparam int LW = $clog2(MAX_LEXEME + 1);
    localparam logic [NUM_KW-1:0] KW_ALL = '1;

    logic [7:0]        chr_reg;
    logic              eoi_reg;
    logic [4:0]        mode_reg, mode_next;
    logic [2:0]        pend_reg, pend_next;
    logic [LW-1:0]     len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [NUM_KW-1:0] cand_reg, cand_next;
    logic [AW-1:0]     idx_reg, idx_next;

    logic       ovalid_reg, ovalid_next;
    logic [5:0] okind_reg, okind_next;
    logic [7:0] ochar_reg, ochar_next;
    logic       olast_reg, olast_next;
    logic       otrunc_reg, otrunc_next;

    logic [7:0] rdata;
    logic       wordc;

    // direct consumption
    logic       is_direct, dir_emit, dir_append;
    logic [5:0] dir_kind;
    logic [4:0] dir_mode;
    logic [2:0] dir_pend;

    // beats before the character is handled from idle
    logic       pre_word, pre_beat;
    logic [5:0] pre_kind;

    // handling from idle
    logic       t_emit, t_append;
    logic [5:0] t_kind;
    logic [4:0] t_mode;
    logic [2:0] t_pend;

    logic       kw_hit;
    logic [5:0] kw_kind;
    logic [5:0] res_kind;
    logic       op_match;
    logic [5:0] op_kind;
    logic [7:0] rest_ch;
    logic [6:0] sop;

    // append unit
    logic              a_tail;
    logic [LW-1:0]     a_len;
    logic [NUM_KW-1:0] a_match;
    logic              a_room;
    logic              do_append;
    logic              word_last;

    assign wordc = is_alpha(chr_reg) || is_digit(chr_reg);
    assign sop   = single_op(chr_reg);

    always_comb begin
        kw_hit  = 1'b0;
        kw_kind = K_ERR;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (cand_reg[k] && 6'(len_reg) == {2'b00, kw_len(4'(k))}) begin
                kw_hit  = 1'b1;
                kw_kind = K_KW0 + 6'(k);
            end
        end
        if (mode_reg != M_IDENT || ovf_reg) begin
            kw_hit = 1'b0;
        end
    end

    always_comb begin
        case (pend_reg)
            P_GT:    res_kind = K_GT;
            P_LT:    res_kind = K_LT;
            P_EQ:    res_kind = K_EQ;
            default: res_kind = K_ERR;
        endcase
        op_match = 1'b0;
        op_kind  = K_ERR;
        case (pend_reg)
            P_BAR:  begin op_match = (chr_reg == "|"); op_kind = K_OROR; end
            P_BANG: begin op_match = (chr_reg == "="); op_kind = K_NE;   end
            P_GT:   begin op_match = (chr_reg == "="); op_kind = K_GE;   end
            P_LT:   begin op_match = (chr_reg == "="); op_kind = K_LE;   end
            P_EQ:   begin op_match = (chr_reg == "="); op_kind = K_EQEQ; end
            default: ;
        endcase
        case (mode_reg)
            M_S, M_STAR: rest_ch = "t";
            M_ST:        rest_ch = "a";
            M_STA:       rest_ch = "r";
            M_E:         rest_ch = "n";
            M_EN:        rest_ch = "d";
            default:     rest_ch = 8'd0;
        endcase
    end

    // classify the held item against the current mode
    always_comb begin
        is_direct  = 1'b0;
        dir_emit   = 1'b0;
        dir_append = 1'b0;
        dir_kind   = K_ERR;
        dir_mode   = mode_reg;
        dir_pend   = pend_reg;
        pre_word   = 1'b0;
        pre_beat   = 1'b0;
        pre_kind   = K_ERR;
        if (eoi_reg) begin
            case (mode_reg) inside
                M_IDENT, M_INT, M_FRAC: begin
                    pre_word = !kw_hit;
                    pre_beat = kw_hit;
                    pre_kind = kw_kind;
                end
                M_START: begin pre_beat = 1'b1; pre_kind = K_START; end
                M_END:   begin pre_beat = 1'b1; pre_kind = K_END;   end
                [M_DOT:M_EN]: pre_beat = 1'b1;
                M_OP:    begin pre_beat = 1'b1; pre_kind = res_kind; end
                default: ;
            endcase
        end else begin
            case (mode_reg) inside
                M_IDENT, M_INT, M_FRAC: begin
                    if ((mode_reg == M_IDENT && wordc) ||
                        (mode_reg != M_IDENT && is_digit(chr_reg))) begin
                        is_direct  = 1'b1;
                        dir_append = 1'b1;
                    end else if (mode_reg == M_INT && chr_reg == ".") begin
                        is_direct  = 1'b1;
                        dir_append = 1'b1;
                        dir_mode   = M_FRAC;
                    end else begin
                        pre_word = !kw_hit;
                        pre_beat = kw_hit;
                        pre_kind = kw_kind;
                    end
                end
                M_DOT: begin
                    if (chr_reg == "s") begin
                        is_direct = 1'b1;
                        dir_mode  = M_S;
                    end else if (chr_reg == "e") begin
                        is_direct = 1'b1;
                        dir_mode  = M_E;
                    end else begin
                        pre_beat = 1'b1;
                    end
                end
                M_S, M_ST, M_STA, M_STAR, M_E, M_EN: begin
                    if (chr_reg == rest_ch) begin
                        is_direct = 1'b1;
                        dir_mode  = mode_reg + 5'd1;
                    end else begin
                        pre_beat = 1'b1;
                    end
                end
                M_START, M_END: begin
                    if (is_space(chr_reg)) begin
                        is_direct = 1'b1;
                        dir_emit  = 1'b1;
                        dir_kind  = (mode_reg == M_START) ? K_START : K_END;
                        dir_mode  = M_IDLE;
                    end else begin
                        pre_beat = 1'b1;
                    end
                end
                M_OP: begin
                    if (op_match) begin
                        is_direct = 1'b1;
                        dir_emit  = 1'b1;
                        dir_kind  = op_kind;
                        dir_mode  = M_IDLE;
                        dir_pend  = P_NONE;
                    end else begin
                        pre_beat = 1'b1;
                        pre_kind = res_kind;
                    end
                end
                default: ;
            endcase
        end
    end

    // the held character taken from idle, or a return to reset at end of input
    always_comb begin
        t_emit   = 1'b0;
        t_append = 1'b0;
        t_kind   = K_ERR;
        t_mode   = M_IDLE;
        t_pend   = P_NONE;
        if (!eoi_reg) begin
            if (is_space(chr_reg)) begin
                t_mode = M_IDLE;
            end else if (is_alpha(chr_reg)) begin
                t_append = 1'b1;
                t_mode   = M_IDENT;
            end else if (is_digit(chr_reg)) begin
                t_append = 1'b1;
                t_mode   = M_INT;
            end else if (chr_reg == ".") begin
                t_mode = M_DOT;
            end else if (sop[6]) begin
                t_emit = 1'b1;
                t_kind = sop[5:0];
            end else if (chr_reg == "|") begin
                t_mode = M_OP;
                t_pend = P_BAR;
            end else if (chr_reg == "!") begin
                t_mode = M_OP;
                t_pend = P_BANG;
            end else if (chr_reg == ">") begin
                t_mode = M_OP;
                t_pend = P_GT;
            end else if (chr_reg == "<") begin
                t_mode = M_OP;
                t_pend = P_LT;
            end else if (chr_reg == "=") begin
                t_mode = M_OP;
                t_pend = P_EQ;
            end else begin
                t_emit = 1'b1;
            end
        end
    end

    // keyword candidate update for one appended character
    assign a_tail = cmd.tail;
    assign a_len  = a_tail ? '0 : len_reg;
    assign a_room = 6'(a_len) < 6'(MAX_LEXEME);

    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            a_match[k] = (6'(a_len) < {2'b00, kw_len(4'(k))}) &&
                         (kw_char(4'(k), 3'(a_len)) == chr_reg);
        end
    end

    assign do_append = (cmd.step_direct && dir_append) || (cmd.tail && t_append);

    always_comb begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        cand_next = cand_reg;
        if (cmd.step_direct) begin
            mode_next = dir_mode;
            pend_next = dir_pend;
        end
        if (cmd.tail) begin
            mode_next = t_mode;
            pend_next = t_pend;
            len_next  = '0;
            ovf_next  = 1'b0;
            cand_next = KW_ALL;
        end
        if (do_append) begin
            if (a_room) begin
                len_next  = a_len + LW'(1);
                cand_next = (a_tail ? KW_ALL : cand_reg) & a_match;
            end else begin
                ovf_next  = 1'b1;
                cand_next = '0;
            end
        end
    end

    klex_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEXEME)
    ) u_buf (
        .aclk  (aclk),
        .we    (do_append && a_room),
        .waddr (a_len[AW-1:0]),
        .wdata (chr_reg),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign word_last = (LW'(idx_reg) + LW'(1)) == len_reg;

    always_comb begin
        idx_next = idx_reg;
        if (cmd.word_start) begin
            idx_next = '0;
        end else if (cmd.word_next) begin
            idx_next = idx_reg + AW'(1);
        end
    end

    // output register
    always_comb begin
        ovalid_next = ovalid_reg && !out_ready;
        okind_next  = okind_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        otrunc_next = otrunc_reg;
        if (cmd.osel != OSEL_NONE) begin
            ovalid_next = 1'b1;
            ochar_next  = 8'd0;
            olast_next  = 1'b1;
            otrunc_next = 1'b0;
        end
        case (cmd.osel)
            OSEL_DIRECT: okind_next = dir_kind;
            OSEL_PRE:    okind_next = pre_kind;
            OSEL_TAIL:   okind_next = t_kind;
            OSEL_WORD: begin
                okind_next  = (mode_reg == M_IDENT) ? K_IDENT : K_NUM;
                ochar_next  = rdata;
                olast_next  = word_last;
                otrunc_next = ovf_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pend_reg   <= P_NONE;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            cand_reg   <= KW_ALL;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            cand_reg   <= cand_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            chr_reg <= in_char;
            eoi_reg <= in_eoi;
        end
        okind_reg  <= okind_next;
        ochar_reg  <= ochar_next;
        olast_reg  <= olast_next;
        otrunc_reg <= otrunc_next;
    end

    assign stat.is_direct = is_direct;
    assign stat.dir_emit  = dir_emit;
    assign stat.pre_word  = pre_word;
    assign stat.pre_beat  = pre_beat;
    assign stat.tail_emit = t_emit;
    assign stat.word_last = word_last;
    assign stat.out_free  = !ovalid_reg || out_ready;

    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;
    assign out_trunc = otrunc_reg;

endmodule

FILE: rtl/core/klex_ctrl.sv
// lexer controller: sequences capture, word readout and the beats of one item
module klex_ctrl
    import klex_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  klex_stat_t stat,
    output klex_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_WADDR  = 3'd2;
    localparam logic [2:0] S_WORD   = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.is_direct) begin
                    if (!stat.dir_emit || stat.out_free) begin
                        cmd.step_direct = 1'b1;
                        cmd.osel        = stat.dir_emit ? OSEL_DIRECT : OSEL_NONE;
                        state_next      = S_IDLE;
                    end
                end else if (stat.pre_word) begin
                    cmd.word_start = 1'b1;
                    state_next     = S_WADDR;
                end else if (stat.pre_beat) begin
                    if (stat.out_free) begin
                        cmd.osel   = OSEL_PRE;
                        state_next = S_TAIL;
                    end
                end else begin
                    state_next = S_TAIL;
                end
            end
            // buffer read address settles, data is there next cycle
            S_WADDR: state_next = S_WORD;
            S_WORD: begin
                if (stat.out_free) begin
                    cmd.osel = OSEL_WORD;
                    if (stat.word_last) begin
                        state_next = S_TAIL;
                    end else begin
                        cmd.word_next = 1'b1;
                        state_next    = S_WADDR;
                    end
                end
            end
            S_TAIL: begin
                if (!stat.tail_emit || stat.out_free) begin
                    cmd.tail   = 1'b1;
                    cmd.osel   = stat.tail_emit ? OSEL_TAIL : OSEL_NONE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/keyword_identifier_lexer_top.sv
// Character-stream lexer: one byte (or an end-of-input marker) per input transfer,
// one result transfer per token beat. Identifiers and numbers come out one character
// per transfer (kind identifier or number, tlast on the final character, truncated set
// when the word exceeded MAX_LEXEME characters); keywords, directives, operators and
// errors are single transfers with lexeme_char zero. A character that continues a word,
// directive or two-character operator is captured, then consumed directly; one that ends
// a token passes the decide state, an address and a word state per character read back
// from the lexeme buffer (its registered read port paces the word readout) and the tail
// state. The output register accepts stalls on the result side without losing beats.
module keyword_identifier_lexer_top
    import klex_pkg::*;
#(
    parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic [0:0] s_tuser,   // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] lexeme_char
    output logic [7:0] m_tuser,   // [5:0] token_kind, [6] truncated, [7] zero
    output logic       m_tlast
);

    klex_cmd_t  cmd;
    klex_stat_t stat;
    logic [5:0] kind;
    logic       trunc;

    klex_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    klex_datapath #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_char   (s_tdata),
        .in_eoi    (s_tuser[0]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (kind),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_trunc (trunc)
    );

    assign m_tuser = {1'b0, trunc, kind};

endmodule
